// ===== sv/cidtm_pkg.sv =====
// Shared types, constants and helper functions of the CAN ID traffic monitor.
package cidtm_pkg;

    localparam int TBL_DEPTH  = 32;
    localparam int IDX_W      = $clog2(TBL_DEPTH);
    localparam int CNT_W      = $clog2(TBL_DEPTH + 1);
    localparam int EXCL_SLOTS = 4;
    localparam int ID_W       = 29;
    localparam int LEN_W      = 4;
    localparam int PAY_W      = 64;
    localparam int TS_W       = 32;
    localparam int CTR_W      = 32;
    localparam int ECNT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 264;
    localparam int M_TUSER_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEL_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_CNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_C   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_D   = 3'd6;

    localparam logic [TS_W-1:0] PERIOD_RESET = 32'd1000000;
    localparam logic [LEN_W-1:0] MAX_LEN     = 4'd8;

    localparam logic [M_TUSER_W-1:0] RK_FWD  = 2'd0;
    localparam logic [M_TUSER_W-1:0] RK_SEL  = 2'd1;
    localparam logic [M_TUSER_W-1:0] RK_PER  = 2'd2;
    localparam logic [M_TUSER_W-1:0] RK_FULL = 2'd3;

    localparam logic KIND_FRAME = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]                  sel_id;
        logic [TS_W-1:0]                  period;
        logic [ECNT_W-1:0]                excl_cnt;
        logic [EXCL_SLOTS-1:0][ID_W-1:0]  excl_ids;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic             fwd;
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        logic [PAY_W-1:0] pay;
        logic [TS_W-1:0]  ts;
        logic             act;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]  ident;
        logic [LEN_W-1:0] length;
        logic [PAY_W-1:0] bytes;
        logic [TS_W-1:0]  stamp;
        logic [CTR_W-1:0] total;
        logic [CTR_W-1:0] changes;
        logic [CTR_W-1:0] wframes;
        logic [CTR_W-1:0] wchanges;
        logic             changed;
        logic             active;
    } t_entry;

    typedef enum logic [1:0] {
        TOP_NOP,
        TOP_WRITE,
        TOP_CLEAR
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op          op;
        logic [IDX_W-1:0] idx;
        t_entry           ent;
    } t_tbl_cmd;

    typedef struct packed {
        logic [M_TUSER_W-1:0] kind;
        logic [ID_W-1:0]      id;
        logic [LEN_W-1:0]     len;
        logic [PAY_W-1:0]     pay;
        logic [TS_W-1:0]      ts;
        logic [CTR_W-1:0]     total;
        logic [CTR_W-1:0]     changes;
        logic [CTR_W-1:0]     frate;
        logic [CTR_W-1:0]     crate;
        logic                 act;
        logic                 inl;
    } t_row;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FWD,
        ST_FULL,
        ST_SEL,
        ST_SORT,
        ST_PEMIT,
        ST_CLEAR
    } t_state;

    function automatic logic f_excluded(input t_cfg cfg, input logic [ID_W-1:0] id);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < EXCL_SLOTS; i++) begin
            if ((cfg.excl_cnt > ECNT_W'(i)) && (cfg.excl_ids[i] == id)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [CTR_W-1:0] f_sat_inc(input logic [CTR_W-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    function automatic logic [LEN_W-1:0] f_sat_len(input logic [LEN_W-1:0] len);
        return len[3] ? MAX_LEN : len;
    endfunction

    function automatic logic [PAY_W-1:0] f_byte_mask(input logic [LEN_W-1:0] len);
        logic [5:0] sh;
        sh = {len[2:0], 3'b000};
        return len[3] ? {PAY_W{1'b1}} : ((PAY_W'(1) << sh) - PAY_W'(1));
    endfunction

endpackage

// ===== sv/cidtm_front.sv =====
// Input side: accepts requests, marks frames for forwarding and queues them.
module cidtm_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cidtm_pkg::t_cfg                   i_cfg,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [cidtm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_s_tuser,
    output logic                              o_q_valid,
    output cidtm_pkg::t_item                  o_q_item,
    input  logic                              i_q_pop
);

    cidtm_pkg::t_item r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    cidtm_pkg::t_item w_item;
    logic             w_push;

    always_comb begin
        w_item.kind = i_s_tuser;
        w_item.id   = i_s_tdata[28:0];
        w_item.len  = i_s_tdata[32:29];
        w_item.pay  = i_s_tdata[96:33];
        w_item.ts   = i_s_tdata[128:97];
        w_item.act  = i_s_tdata[129];
        w_item.fwd  = (i_s_tuser == cidtm_pkg::KIND_FRAME) && (i_cfg.excl_cnt != '0)
                      && !cidtm_pkg::f_excluded(i_cfg, i_s_tdata[28:0]);
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

endmodule

// ===== sv/cidtm_table.sv =====
// Per-ID entry table with one read index, one write command and a window clear.
module cidtm_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [cidtm_pkg::IDX_W-1:0]       i_rd_idx,
    output cidtm_pkg::t_entry                 o_rd_ent,
    output logic [cidtm_pkg::TBL_DEPTH-1:0]   o_valid,
    input  cidtm_pkg::t_tbl_cmd               i_cmd
);

    cidtm_pkg::t_entry                r_ent [cidtm_pkg::TBL_DEPTH];
    logic [cidtm_pkg::TBL_DEPTH-1:0]  r_valid;

    assign o_rd_ent = r_ent[i_rd_idx];
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.op == cidtm_pkg::TOP_WRITE) begin
            r_valid[i_cmd.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cidtm_pkg::TOP_WRITE: begin
                r_ent[i_cmd.idx] <= i_cmd.ent;
            end
            cidtm_pkg::TOP_CLEAR: begin
                for (int i = 0; i < cidtm_pkg::TBL_DEPTH; i++) begin
                    if (r_valid[i]) begin
                        r_ent[i].wframes  <= '0;
                        r_ent[i].wchanges <= '0;
                        r_ent[i].changed  <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/cidtm_back.sv =====
// Sequencer: table search, entry update, reports, sorted periodic dump and output register.
module cidtm_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cidtm_pkg::t_cfg                   i_cfg,
    input  logic                              i_q_valid,
    input  cidtm_pkg::t_item                  i_q_item,
    output logic                              o_q_pop,
    output logic [cidtm_pkg::IDX_W-1:0]       o_rd_idx,
    input  cidtm_pkg::t_entry                 i_rd_ent,
    input  logic [cidtm_pkg::TBL_DEPTH-1:0]   i_valid,
    output cidtm_pkg::t_tbl_cmd               o_cmd,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output cidtm_pkg::t_row                   o_m_row,
    output logic                              o_m_tlast
);

    localparam logic [cidtm_pkg::IDX_W-1:0] LAST_IDX = cidtm_pkg::IDX_W'(cidtm_pkg::TBL_DEPTH - 1);

    cidtm_pkg::t_state                r_state;
    cidtm_pkg::t_state                n_state;
    cidtm_pkg::t_item                 r_item;
    logic [cidtm_pkg::IDX_W-1:0]      r_idx;
    logic                             r_found;
    logic [cidtm_pkg::IDX_W-1:0]      r_match;
    logic                             r_free_found;
    logic [cidtm_pkg::IDX_W-1:0]      r_free;
    logic                             r_full;
    logic                             r_sel;
    logic                             r_per;
    logic [cidtm_pkg::CNT_W-1:0]      r_count;
    logic                             r_started;
    logic [cidtm_pkg::TS_W-1:0]       r_last_rep;
    logic [cidtm_pkg::TS_W-1:0]       r_sel_win;
    logic [cidtm_pkg::CTR_W-1:0]      r_sel_prev_tot;
    logic [cidtm_pkg::CTR_W-1:0]      r_sel_prev_chg;
    logic [cidtm_pkg::CTR_W-1:0]      r_sel_rate;
    logic [cidtm_pkg::CTR_W-1:0]      r_sel_crate;
    logic [cidtm_pkg::TBL_DEPTH-1:0]  r_done;
    logic [cidtm_pkg::CNT_W-1:0]      r_emitted;
    logic                             r_best_found;
    logic [cidtm_pkg::IDX_W-1:0]      r_best;
    logic [cidtm_pkg::CTR_W-1:0]      r_best_fr;
    logic [cidtm_pkg::ID_W-1:0]       r_best_id;
    logic                             r_out_valid;
    cidtm_pkg::t_row                  r_out_row;
    logic                             r_out_last;

    logic                             w_out_free;
    logic                             w_emit;
    cidtm_pkg::t_row                  w_row;
    logic                             w_last;
    logic                             d_full;
    logic                             d_sel;
    logic                             d_per;
    logic                             d_ins;
    logic [cidtm_pkg::CNT_W-1:0]      d_cnt;
    logic                             w_sel_hit;
    logic [cidtm_pkg::CTR_W-1:0]      w_sel_rate;
    logic [cidtm_pkg::CTR_W-1:0]      w_sel_crate;
    logic                             w_better;
    logic                             w_pdone;
    logic [cidtm_pkg::LEN_W-1:0]      w_len;
    logic [cidtm_pkg::PAY_W-1:0]      w_mask;
    logic                             w_diff;
    cidtm_pkg::t_entry                w_upd;
    cidtm_pkg::t_entry                w_new;

    function automatic cidtm_pkg::t_state f_after(input logic per,
                                                  input logic [cidtm_pkg::CNT_W-1:0] cnt);
        cidtm_pkg::t_state s;
        s = cidtm_pkg::ST_IDLE;
        if (per) begin
            s = (cnt != '0) ? cidtm_pkg::ST_SORT : cidtm_pkg::ST_CLEAR;
        end
        return s;
    endfunction

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_row    = r_out_row;
    assign o_m_tlast  = r_out_last;

    always_comb begin
        unique case (r_state)
            cidtm_pkg::ST_DECIDE, cidtm_pkg::ST_SEL: o_rd_idx = r_match;
            cidtm_pkg::ST_PEMIT:                     o_rd_idx = r_best;
            default:                                 o_rd_idx = r_idx;
        endcase
    end

    // Decisions made once the search has finished.
    always_comb begin
        d_ins  = !r_found && r_free_found;
        d_full = !r_found && !r_free_found;
        d_sel  = r_found && (r_item.id == i_cfg.sel_id);
        d_per  = (r_item.ts - r_last_rep) > i_cfg.period;
        d_cnt  = r_count + cidtm_pkg::CNT_W'(d_ins);
    end

    always_comb begin
        w_len  = cidtm_pkg::f_sat_len(r_item.len);
        w_mask = cidtm_pkg::f_byte_mask(w_len);
        w_diff = |((i_rd_ent.bytes ^ r_item.pay) & w_mask);

        w_upd         = i_rd_ent;
        w_upd.total   = cidtm_pkg::f_sat_inc(i_rd_ent.total);
        w_upd.wframes = cidtm_pkg::f_sat_inc(i_rd_ent.wframes);
        w_upd.stamp   = r_item.ts;
        w_upd.length  = w_len;
        w_upd.bytes   = r_item.pay & w_mask;
        w_upd.changed = w_diff;
        if (w_diff) begin
            w_upd.changes  = cidtm_pkg::f_sat_inc(i_rd_ent.changes);
            w_upd.wchanges = cidtm_pkg::f_sat_inc(i_rd_ent.wchanges);
        end

        w_new.ident    = r_item.id;
        w_new.length   = w_len;
        w_new.bytes    = r_item.pay & w_mask;
        w_new.stamp    = r_item.ts;
        w_new.total    = cidtm_pkg::CTR_W'(1);
        w_new.changes  = cidtm_pkg::CTR_W'(1);
        w_new.wframes  = cidtm_pkg::CTR_W'(1);
        w_new.wchanges = cidtm_pkg::CTR_W'(1);
        w_new.changed  = 1'b1;
        w_new.active   = 1'b1;
    end

    always_comb begin
        w_sel_hit   = (r_item.ts - r_sel_win) > i_cfg.period;
        w_sel_rate  = w_sel_hit ? i_rd_ent.total - r_sel_prev_tot : r_sel_rate;
        w_sel_crate = w_sel_hit ? i_rd_ent.changes - r_sel_prev_chg : r_sel_crate;
    end

    always_comb begin
        w_better = i_valid[r_idx] && !r_done[r_idx]
                   && (!r_best_found || (i_rd_ent.wframes > r_best_fr)
                       || ((i_rd_ent.wframes == r_best_fr) && (i_rd_ent.ident < r_best_id)));
        w_pdone  = (cidtm_pkg::CNT_W'(r_emitted + 1'b1) == r_count);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cidtm_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = cidtm_pkg::ST_SCAN;
                end
            end
            cidtm_pkg::ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = cidtm_pkg::ST_DECIDE;
                end
            end
            cidtm_pkg::ST_DECIDE: begin
                if (r_item.kind != cidtm_pkg::KIND_FRAME) begin
                    n_state = cidtm_pkg::ST_IDLE;
                end else if (r_item.fwd) begin
                    n_state = cidtm_pkg::ST_FWD;
                end else if (d_full) begin
                    n_state = cidtm_pkg::ST_FULL;
                end else if (d_sel) begin
                    n_state = cidtm_pkg::ST_SEL;
                end else begin
                    n_state = f_after(d_per, d_cnt);
                end
            end
            cidtm_pkg::ST_FWD: begin
                if (w_out_free) begin
                    if (r_full) begin
                        n_state = cidtm_pkg::ST_FULL;
                    end else if (r_sel) begin
                        n_state = cidtm_pkg::ST_SEL;
                    end else begin
                        n_state = f_after(r_per, r_count);
                    end
                end
            end
            cidtm_pkg::ST_FULL, cidtm_pkg::ST_SEL: begin
                if (w_out_free) begin
                    n_state = f_after(r_per, r_count);
                end
            end
            cidtm_pkg::ST_SORT: begin
                if (r_idx == LAST_IDX) begin
                    n_state = cidtm_pkg::ST_PEMIT;
                end
            end
            cidtm_pkg::ST_PEMIT: begin
                if (w_out_free) begin
                    n_state = w_pdone ? cidtm_pkg::ST_CLEAR : cidtm_pkg::ST_SORT;
                end
            end
            cidtm_pkg::ST_CLEAR: begin
                n_state = cidtm_pkg::ST_IDLE;
            end
            default: begin
                n_state = cidtm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        w_emit    = 1'b0;
        w_row     = '0;
        w_last    = 1'b0;
        o_cmd.op  = cidtm_pkg::TOP_NOP;
        o_cmd.idx = r_match;
        o_cmd.ent = w_upd;
        unique case (r_state)
            cidtm_pkg::ST_IDLE: begin
                o_q_pop = i_q_valid;
            end
            cidtm_pkg::ST_DECIDE: begin
                if (r_item.kind != cidtm_pkg::KIND_FRAME) begin
                    o_cmd.ent        = i_rd_ent;
                    o_cmd.ent.active = r_item.act;
                    if (r_found) begin
                        o_cmd.op = cidtm_pkg::TOP_WRITE;
                    end
                end else if (r_found) begin
                    o_cmd.op = cidtm_pkg::TOP_WRITE;
                end else if (r_free_found) begin
                    o_cmd.op  = cidtm_pkg::TOP_WRITE;
                    o_cmd.idx = r_free;
                    o_cmd.ent = w_new;
                end
            end
            cidtm_pkg::ST_FWD: begin
                w_emit     = w_out_free;
                w_row.kind = cidtm_pkg::RK_FWD;
                w_row.id   = r_item.id;
                w_row.len  = r_item.len;
                w_row.pay  = r_item.pay;
                w_row.ts   = r_item.ts;
                w_last     = !(r_full || r_sel || (r_per && (r_count != '0)));
            end
            cidtm_pkg::ST_FULL: begin
                w_emit     = w_out_free;
                w_row.kind = cidtm_pkg::RK_FULL;
                w_row.id   = r_item.id;
                w_row.ts   = r_item.ts;
                w_last     = !(r_per && (r_count != '0));
            end
            cidtm_pkg::ST_SEL: begin
                w_emit        = w_out_free;
                w_row.kind    = cidtm_pkg::RK_SEL;
                w_row.id      = i_rd_ent.ident;
                w_row.len     = i_rd_ent.length;
                w_row.pay     = i_rd_ent.bytes;
                w_row.ts      = i_rd_ent.stamp;
                w_row.total   = i_rd_ent.total;
                w_row.changes = i_rd_ent.changes;
                w_row.frate   = w_sel_rate;
                w_row.crate   = w_sel_crate;
                w_row.act     = i_rd_ent.active;
                w_last        = !r_per;
            end
            cidtm_pkg::ST_PEMIT: begin
                w_emit        = w_out_free;
                w_row.kind    = cidtm_pkg::RK_PER;
                w_row.id      = i_rd_ent.ident;
                w_row.len     = i_rd_ent.length;
                w_row.pay     = i_rd_ent.bytes;
                w_row.ts      = i_rd_ent.stamp;
                w_row.total   = i_rd_ent.total;
                w_row.changes = i_rd_ent.changes;
                w_row.frate   = i_rd_ent.wframes;
                w_row.crate   = i_rd_ent.wchanges;
                w_row.act     = i_rd_ent.active;
                w_row.inl     = i_rd_ent.changed
                                && !((i_cfg.excl_cnt != '0)
                                     && cidtm_pkg::f_excluded(i_cfg, i_rd_ent.ident));
                w_last        = w_pdone;
            end
            cidtm_pkg::ST_CLEAR: begin
                o_cmd.op = cidtm_pkg::TOP_CLEAR;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= cidtm_pkg::ST_IDLE;
            r_count        <= '0;
            r_started      <= 1'b0;
            r_last_rep     <= '0;
            r_sel_win      <= '0;
            r_sel_prev_tot <= '0;
            r_sel_prev_chg <= '0;
            r_sel_rate     <= '0;
            r_sel_crate    <= '0;
            r_out_valid    <= 1'b0;
            r_found        <= 1'b0;
            r_free_found   <= 1'b0;
            r_best_found   <= 1'b0;
            r_idx          <= '0;
            r_emitted      <= '0;
            r_done         <= '0;
        end else begin
            r_state <= n_state;

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                cidtm_pkg::ST_IDLE: begin
                    if (i_q_valid) begin
                        r_idx        <= '0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        if ((i_q_item.kind == cidtm_pkg::KIND_FRAME) && !r_started) begin
                            r_started  <= 1'b1;
                            r_last_rep <= i_q_item.ts;
                            r_sel_win  <= i_q_item.ts;
                        end
                    end
                end
                cidtm_pkg::ST_SCAN: begin
                    r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                    if (i_valid[r_idx] && (i_rd_ent.ident == r_item.id) && !r_found) begin
                        r_found <= 1'b1;
                    end
                    if (!i_valid[r_idx] && !r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                end
                cidtm_pkg::ST_DECIDE: begin
                    if (r_item.kind == cidtm_pkg::KIND_FRAME) begin
                        r_count <= d_cnt;
                    end
                end
                cidtm_pkg::ST_SEL: begin
                    if (w_out_free && w_sel_hit) begin
                        r_sel_rate     <= w_sel_rate;
                        r_sel_crate    <= w_sel_crate;
                        r_sel_win      <= r_item.ts;
                        r_sel_prev_tot <= i_rd_ent.total;
                        r_sel_prev_chg <= i_rd_ent.changes;
                    end
                end
                cidtm_pkg::ST_SORT: begin
                    r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                    if (w_better) begin
                        r_best_found <= 1'b1;
                    end
                end
                cidtm_pkg::ST_PEMIT: begin
                    if (w_out_free) begin
                        r_done[r_best] <= 1'b1;
                        r_emitted      <= r_emitted + 1'b1;
                    end
                end
                cidtm_pkg::ST_CLEAR: begin
                    r_last_rep <= r_item.ts;
                end
                default: begin
                end
            endcase

            if ((n_state == cidtm_pkg::ST_SORT) && (r_state != cidtm_pkg::ST_SORT)) begin
                r_idx        <= '0;
                r_best_found <= 1'b0;
                if (r_state != cidtm_pkg::ST_PEMIT) begin
                    r_done    <= '0;
                    r_emitted <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_row  <= w_row;
            r_out_last <= w_last;
        end
        if ((r_state == cidtm_pkg::ST_IDLE) && i_q_valid) begin
            r_item <= i_q_item;
        end
        if (r_state == cidtm_pkg::ST_SCAN) begin
            if (i_valid[r_idx] && (i_rd_ent.ident == r_item.id) && !r_found) begin
                r_match <= r_idx;
            end
            if (!i_valid[r_idx] && !r_free_found) begin
                r_free <= r_idx;
            end
        end
        if (r_state == cidtm_pkg::ST_DECIDE) begin
            r_full <= d_full;
            r_sel  <= d_sel;
            r_per  <= d_per;
        end
        if ((r_state == cidtm_pkg::ST_SORT) && w_better) begin
            r_best    <= r_idx;
            r_best_fr <= i_rd_ent.wframes;
            r_best_id <= i_rd_ent.ident;
        end
    end

endmodule

// ===== sv/can_id_traffic_monitor_unit.sv =====
// Top level of the CAN ID traffic monitor: configuration registers, queue, table and sequencer.
//
// Each request is held in a two-deep input queue and then handled on its own by the
// sequencer. A request walks the whole ID table once, one entry per cycle, and each
// result it produces is then passed on through the output register.
// When the report period lapses, the sorted dump walks the table again for every valid
// entry, followed by a clear state that resets the window counts. Output stalls hold
// the sequencer, not the input queue.
module can_id_traffic_monitor_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cidtm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cidtm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // frame_id, frame_len, payload, arrival_time, active_value, zero fill
    input  logic [cidtm_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // kind
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // entry_id, entry_len, entry_payload, entry_time, total_count, change_count,
    // frame_rate, change_rate, is_active, in_changed_list, zero fill
    output logic [cidtm_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // result_kind
    output logic [cidtm_pkg::M_TUSER_W-1:0]    o_m_tuser,
    output logic                               o_m_tlast
);

    cidtm_pkg::t_cfg                  r_cfg;
    logic                             w_q_valid;
    cidtm_pkg::t_item                 w_q_item;
    logic                             w_q_pop;
    logic [cidtm_pkg::IDX_W-1:0]      w_rd_idx;
    cidtm_pkg::t_entry                w_rd_ent;
    logic [cidtm_pkg::TBL_DEPTH-1:0]  w_valid;
    cidtm_pkg::t_tbl_cmd              w_cmd;
    cidtm_pkg::t_row                  w_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sel_id   <= '0;
            r_cfg.period   <= cidtm_pkg::PERIOD_RESET;
            r_cfg.excl_cnt <= '0;
            r_cfg.excl_ids <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cidtm_pkg::CFG_SEL_ID:   r_cfg.sel_id      <= i_cfg_data[28:0];
                cidtm_pkg::CFG_PERIOD:   r_cfg.period      <= i_cfg_data;
                cidtm_pkg::CFG_EXCL_CNT: r_cfg.excl_cnt    <= i_cfg_data[2:0];
                cidtm_pkg::CFG_EXCL_A:   r_cfg.excl_ids[0] <= i_cfg_data[28:0];
                cidtm_pkg::CFG_EXCL_B:   r_cfg.excl_ids[1] <= i_cfg_data[28:0];
                cidtm_pkg::CFG_EXCL_C:   r_cfg.excl_ids[2] <= i_cfg_data[28:0];
                cidtm_pkg::CFG_EXCL_D:   r_cfg.excl_ids[3] <= i_cfg_data[28:0];
                default: begin
                end
            endcase
        end
    end

    cidtm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    cidtm_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (w_rd_idx),
        .o_rd_ent (w_rd_ent),
        .o_valid  (w_valid),
        .i_cmd    (w_cmd)
    );

    cidtm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_rd_idx   (w_rd_idx),
        .i_rd_ent   (w_rd_ent),
        .i_valid    (w_valid),
        .o_cmd      (w_cmd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_row    (w_row),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_m_tuser = w_row.kind;
    assign o_m_tdata = {5'b0, w_row.inl, w_row.act, w_row.crate, w_row.frate,
                        w_row.changes, w_row.total, w_row.ts, w_row.pay,
                        w_row.len, w_row.id};

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the CAN ID traffic monitor: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [cidtm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 1500;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int POOL_N        = 40;

    typedef struct {
        logic                        kind;
        logic [cidtm_pkg::ID_W-1:0]  id;
        logic [cidtm_pkg::LEN_W-1:0] len;
        logic [cidtm_pkg::PAY_W-1:0] pay;
        logic [cidtm_pkg::TS_W-1:0]  ts;
        logic                        act;
        int                          n_res;
    } t_request;

    typedef struct {
        cidtm_pkg::t_row row;
        logic            last;
    } t_result;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [cidtm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [cidtm_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [cidtm_pkg::S_TDATA_W-1:0]  i_s_tdata;
    logic                             i_s_tuser;
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    logic [cidtm_pkg::M_TDATA_W-1:0]  o_m_tdata;
    logic [cidtm_pkg::M_TUSER_W-1:0]  o_m_tuser;
    logic                             o_m_tlast;

    can_id_traffic_monitor_unit DUT (.*);

    // Predictor state.
    logic [cidtm_pkg::ID_W-1:0]   cfg_sel;
    logic [cidtm_pkg::TS_W-1:0]   cfg_period;
    logic [cidtm_pkg::ECNT_W-1:0] cfg_ecnt;
    logic [cidtm_pkg::ID_W-1:0]   cfg_excl [cidtm_pkg::EXCL_SLOTS];
    logic                         tbl_vld [cidtm_pkg::TBL_DEPTH];
    cidtm_pkg::t_entry            tbl [cidtm_pkg::TBL_DEPTH];
    logic                         timers_on;
    logic [cidtm_pkg::TS_W-1:0]   report_t, win_t, win_total, win_changes, sel_frate, sel_crate;

    t_result expected_q[$];
    int      n_fail;
    int      cycle_cnt;
    logic    steady;
    logic [cidtm_pkg::ID_W-1:0]  id_pool [POOL_N];
    logic [cidtm_pkg::PAY_W-1:0] pay_pool [4];
    logic [cidtm_pkg::TS_W-1:0]  clock_ts;

    t_request directed [14] = '{
        '{1'b0, 29'h123, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 0},
        '{1'b0, 29'h123, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'd10, 1'b0, 0},
        '{1'b1, 29'h123, 4'd0, 64'h0, 32'd0, 1'b0, 0},
        '{1'b1, 29'h555, 4'd0, 64'h0, 32'd0, 1'b1, 0},
        '{1'b0, 29'h0, 4'd0, 64'h0, 32'd20, 1'b0, 0},
        '{1'b0, 29'h0, 4'd15, 64'hA5A5_5A5A_0F0F_F0F0, 32'd30, 1'b1, 1},
        '{1'b0, 29'h1FFF_FFFF, 4'd4, 64'h0123_4567_89AB_CDEF, 32'd40, 1'b0, 0},
        '{1'b0, 29'h1FFF_FFFF, 4'd4, 64'hFEDC_BA98_89AB_CDEF, 32'd50, 1'b0, 0},
        '{1'b0, 29'h0, 4'd8, 64'h0, 32'd1000000, 1'b0, 1},
        '{1'b0, 29'h7FF, 4'd1, 64'h0000_0000_0000_00C3, 32'd1000001, 1'b0, -1},
        '{1'b0, 29'h0, 4'd8, 64'h1, 32'd2000002, 1'b0, -1},
        '{1'b1, 29'h7FF, 4'd0, 64'h0, 32'd0, 1'b1, 0},
        '{1'b0, 29'h123, 4'd2, 64'h0, 32'hFFFF_FFFF, 1'b0, -1},
        '{1'b0, 29'h2A, 4'd9, 64'h8000_0000_0000_0001, 32'd5, 1'b0, -1}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic is_blocked(input logic [cidtm_pkg::ID_W-1:0] id);
        int n;
        n = (cfg_ecnt > cidtm_pkg::EXCL_SLOTS) ? cidtm_pkg::EXCL_SLOTS : int'(cfg_ecnt);
        for (int i = 0; i < n; i++) if (cfg_excl[i] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [cidtm_pkg::CTR_W-1:0] bump(input logic [cidtm_pkg::CTR_W-1:0] x);
        return (x == '1) ? x : x + 1;
    endfunction

    function automatic void queue_row(input logic [1:0] kind,
            input logic [cidtm_pkg::ID_W-1:0] id, input logic [cidtm_pkg::LEN_W-1:0] len,
            input logic [cidtm_pkg::PAY_W-1:0] pay, input logic [cidtm_pkg::TS_W-1:0] ts,
            input logic [cidtm_pkg::CTR_W-1:0] tot, input logic [cidtm_pkg::CTR_W-1:0] chg,
            input logic [cidtm_pkg::CTR_W-1:0] fr, input logic [cidtm_pkg::CTR_W-1:0] cr,
            input logic act, input logic inl);
        t_result r;
        r.row = '{kind, id, len, pay, ts, tot, chg, fr, cr, act, inl};
        r.last = 1'b0;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void queue_entry(input logic [1:0] kind, input int e,
            input logic [cidtm_pkg::CTR_W-1:0] fr, input logic [cidtm_pkg::CTR_W-1:0] cr,
            input logic inl);
        queue_row(kind, tbl[e].ident, tbl[e].length, tbl[e].bytes, tbl[e].stamp, tbl[e].total,
                  tbl[e].changes, fr, cr, tbl[e].active, inl);
    endfunction

    function automatic int predict_traffic(input t_request r);
        int e, f, best, cnt;
        logic [cidtm_pkg::LEN_W-1:0] len;
        logic [cidtm_pkg::PAY_W-1:0] m;
        logic diff;
        logic taken [cidtm_pkg::TBL_DEPTH];
        cnt = 0;
        e = -1;
        for (int i = 0; i < cidtm_pkg::TBL_DEPTH; i++)
            if (e < 0 && tbl_vld[i] && tbl[i].ident == r.id) e = i;
        if (r.kind != cidtm_pkg::KIND_FRAME) begin
            if (e >= 0) tbl[e].active = r.act;
            return 0;
        end
        if (!timers_on) begin
            timers_on = 1'b1;
            report_t = r.ts;
            win_t = r.ts;
        end
        if (cfg_ecnt != 0 && !is_blocked(r.id)) begin
            queue_row(cidtm_pkg::RK_FWD, r.id, r.len, r.pay, r.ts, '0, '0, '0, '0, 1'b0, 1'b0);
            cnt++;
        end
        len = (r.len > 8) ? 4'd8 : r.len;
        m = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 1);
        if (e < 0) begin
            f = -1;
            for (int i = 0; i < cidtm_pkg::TBL_DEPTH; i++) if (f < 0 && !tbl_vld[i]) f = i;
            if (f < 0) begin
                queue_row(cidtm_pkg::RK_FULL, r.id, '0, '0, r.ts, '0, '0, '0, '0, 1'b0, 1'b0);
                cnt++;
            end else begin
                tbl_vld[f] = 1'b1;
                tbl[f] = '{r.id, len, r.pay & m, r.ts, 1, 1, 1, 1, 1'b1, 1'b1};
            end
        end else begin
            diff = ((tbl[e].bytes ^ r.pay) & m) != 0;
            tbl[e].total = bump(tbl[e].total);
            tbl[e].wframes = bump(tbl[e].wframes);
            tbl[e].stamp = r.ts;
            tbl[e].length = len;
            tbl[e].bytes = r.pay & m;
            tbl[e].changed = diff;
            if (diff) begin
                tbl[e].changes = bump(tbl[e].changes);
                tbl[e].wchanges = bump(tbl[e].wchanges);
            end
            if (r.id == cfg_sel) begin
                if (cidtm_pkg::TS_W'(r.ts - win_t) > cfg_period) begin
                    sel_frate = tbl[e].total - win_total;
                    sel_crate = tbl[e].changes - win_changes;
                    win_t = r.ts;
                    win_total = tbl[e].total;
                    win_changes = tbl[e].changes;
                end
                queue_entry(cidtm_pkg::RK_SEL, e, sel_frate, sel_crate, 1'b0);
                cnt++;
            end
        end
        if (cidtm_pkg::TS_W'(r.ts - report_t) > cfg_period) begin
            for (int i = 0; i < cidtm_pkg::TBL_DEPTH; i++) taken[i] = !tbl_vld[i];
            forever begin
                best = -1;
                for (int i = 0; i < cidtm_pkg::TBL_DEPTH; i++) begin
                    if (taken[i]) continue;
                    if (best < 0 || tbl[i].wframes > tbl[best].wframes ||
                        (tbl[i].wframes == tbl[best].wframes && tbl[i].ident < tbl[best].ident))
                        best = i;
                end
                if (best < 0) break;
                taken[best] = 1'b1;
                queue_entry(cidtm_pkg::RK_PER, best, tbl[best].wframes, tbl[best].wchanges,
                            tbl[best].changed
                            && !(cfg_ecnt != 0 && is_blocked(tbl[best].ident)));
                cnt++;
            end
            for (int i = 0; i < cidtm_pkg::TBL_DEPTH; i++) begin
                if (tbl_vld[i]) begin
                    tbl[i].wframes = 0;
                    tbl[i].wchanges = 0;
                    tbl[i].changed = 1'b0;
                end
            end
            report_t = r.ts;
        end
        if (cnt > 0) expected_q[$].last = 1'b1;
        return cnt;
    endfunction

    task automatic write_reg(input logic [cidtm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cidtm_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        case (idx)
            cidtm_pkg::CFG_SEL_ID:   cfg_sel = d[cidtm_pkg::ID_W-1:0];
            cidtm_pkg::CFG_PERIOD:   cfg_period = d;
            cidtm_pkg::CFG_EXCL_CNT: cfg_ecnt = d[cidtm_pkg::ECNT_W-1:0];
            cidtm_pkg::CFG_EXCL_A:   cfg_excl[0] = d[cidtm_pkg::ID_W-1:0];
            cidtm_pkg::CFG_EXCL_B:   cfg_excl[1] = d[cidtm_pkg::ID_W-1:0];
            cidtm_pkg::CFG_EXCL_C:   cfg_excl[2] = d[cidtm_pkg::ID_W-1:0];
            cidtm_pkg::CFG_EXCL_D:   cfg_excl[3] = d[cidtm_pkg::ID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(input t_request r);
        int n;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 34) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= r.kind;
        i_s_tdata <= cidtm_pkg::S_TDATA_W'({r.act, r.ts, r.pay, r.len, r.id});
        n = predict_traffic(r);
        if (r.n_res >= 0 && n != r.n_res) begin
            $error("result count expected %0d actual %0d", r.n_res, n);
            n_fail++;
        end
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_request random_request();
        t_request r;
        r.kind = ($urandom_range(99) < 10);
        r.id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_N - 1)]
                                         : cidtm_pkg::ID_W'($urandom);
        r.len = cidtm_pkg::LEN_W'($urandom_range(15));
        r.pay = ($urandom_range(99) < 60) ? pay_pool[$urandom_range(3)] : {$urandom, $urandom};
        if ($urandom_range(99) < 5) clock_ts = $urandom;
        else clock_ts = clock_ts + $urandom_range(1, 12);
        r.ts = clock_ts;
        r.act = 1'($urandom_range(1));
        r.n_res = -1;
        return r;
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) send_request(random_request());
        drain();
    endtask

    always @(negedge i_clk)
        i_m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 34);

    always @(posedge i_clk) begin
        t_result x;
        cidtm_pkg::t_row a;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (i_rst_n && o_m_tvalid && i_m_tready) begin
            a = '{o_m_tuser, o_m_tdata[28:0], o_m_tdata[32:29], o_m_tdata[96:33],
                  o_m_tdata[128:97], o_m_tdata[160:129], o_m_tdata[192:161],
                  o_m_tdata[224:193], o_m_tdata[256:225], o_m_tdata[257], o_m_tdata[258]};
            if (expected_q.size() == 0) begin
                $error("result with none expected: kind %0d id %0h", a.kind, a.id);
                n_fail++;
            end else begin
                x = expected_q.pop_front();
                if (x.row !== a || x.last !== o_m_tlast) n_fail++;
                if (x.row.kind !== a.kind)
                    $error("result_kind exp %0d act %0d", x.row.kind, a.kind);
                if (x.row.id !== a.id) $error("entry_id exp %0h act %0h", x.row.id, a.id);
                if (x.row.len !== a.len) $error("entry_len exp %0d act %0d", x.row.len, a.len);
                if (x.row.pay !== a.pay)
                    $error("entry_payload exp %0h act %0h", x.row.pay, a.pay);
                if (x.row.ts !== a.ts) $error("entry_time exp %0h act %0h", x.row.ts, a.ts);
                if (x.row.total !== a.total)
                    $error("total_count exp %0d act %0d", x.row.total, a.total);
                if (x.row.changes !== a.changes)
                    $error("change_count exp %0d act %0d", x.row.changes, a.changes);
                if (x.row.frate !== a.frate)
                    $error("frame_rate exp %0d act %0d", x.row.frate, a.frate);
                if (x.row.crate !== a.crate)
                    $error("change_rate exp %0d act %0d", x.row.crate, a.crate);
                if (x.row.act !== a.act) $error("is_active exp %0d act %0d", x.row.act, a.act);
                if (x.row.inl !== a.inl)
                    $error("in_changed_list exp %0d act %0d", x.row.inl, a.inl);
                if (x.last !== o_m_tlast)
                    $error("last_of_run exp %0d act %0d", x.last, o_m_tlast);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = cidtm_pkg::CFG_SEL_ID;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = cidtm_pkg::KIND_FRAME;
        i_m_tready = 1'b0;
        n_fail = 0;
        cycle_cnt = 0;
        steady = 1'b0;
        cfg_sel = '0;
        cfg_period = cidtm_pkg::PERIOD_RESET;
        cfg_ecnt = '0;
        timers_on = 1'b0;
        {report_t, win_t, win_total, win_changes, sel_frate, sel_crate} = '0;
        for (int i = 0; i < cidtm_pkg::EXCL_SLOTS; i++) cfg_excl[i] = '0;
        for (int i = 0; i < cidtm_pkg::TBL_DEPTH; i++) begin
            tbl_vld[i] = 1'b0;
            tbl[i] = '0;
        end
        for (int i = 0; i < POOL_N; i++) id_pool[i] = cidtm_pkg::ID_W'($urandom);
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 0; i < 4; i++) pay_pool[i] = {$urandom, $urandom};
        clock_ts = 32'd100;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_request(directed[i]);
        drain();

        write_reg(cidtm_pkg::CFG_SEL_ID, cidtm_pkg::CFG_DATA_W'(id_pool[2]));
        write_reg(cidtm_pkg::CFG_PERIOD, 32'd50);
        write_reg(cidtm_pkg::CFG_EXCL_CNT, 32'd2);
        write_reg(cidtm_pkg::CFG_EXCL_A, cidtm_pkg::CFG_DATA_W'(id_pool[3]));
        write_reg(cidtm_pkg::CFG_EXCL_B, cidtm_pkg::CFG_DATA_W'(id_pool[4]));
        write_reg(cidtm_pkg::CFG_EXCL_C, cidtm_pkg::CFG_DATA_W'(id_pool[5]));
        write_reg(cidtm_pkg::CFG_EXCL_D, cidtm_pkg::CFG_DATA_W'(id_pool[6]));
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        end_writes();
        random_phase(60);

        write_reg(cidtm_pkg::CFG_SEL_ID, 32'h1FFF_FFFF);
        write_reg(cidtm_pkg::CFG_PERIOD, 32'd1);
        write_reg(cidtm_pkg::CFG_EXCL_CNT, 32'd7);
        end_writes();
        random_phase(25);

        steady = 1'b1;
        write_reg(cidtm_pkg::CFG_SEL_ID, cidtm_pkg::CFG_DATA_W'(id_pool[7]));
        write_reg(cidtm_pkg::CFG_PERIOD, 32'hFFFF_FFFF);
        write_reg(cidtm_pkg::CFG_EXCL_CNT, 32'd0);
        end_writes();
        random_phase(35);
        steady = 1'b0;

        write_reg(cidtm_pkg::CFG_PERIOD, 32'd200);
        write_reg(cidtm_pkg::CFG_EXCL_CNT, 32'd4);
        write_reg(cidtm_pkg::CFG_EXCL_D, cidtm_pkg::CFG_DATA_W'(id_pool[1]));
        end_writes();
        random_phase(45);

        if (n_fail == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
